>>> hdl/mi3_pkg.sv
// Shared widths, types and index tables for the 3x3 matrix inverse.
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int N_ELEM    = 9;
    localparam int N_ROW     = 3;
    localparam int COF_W     = 64;
    localparam int DET_W     = 98;
    localparam int DM_W      = 97;
    localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
    localparam int Q_W       = 34;
    localparam int CMP_W     = DM_W + Q_W;
    localparam int COF_LAT   = 3;
    localparam int DET_LAT   = 4;
    localparam int LANE_LAT  = Q_W + 1;
    localparam int PIPE_LAT  = COF_LAT + DET_LAT + LANE_LAT;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic        [DM_W-1:0]   dmag_t;
    typedef logic        [Q_W-1:0]    quot_t;
    typedef logic        [3:0]        idx_t;

    localparam quot_t POS_LIMIT = quot_t'(32'h7FFF_FFFF);
    localparam quot_t NEG_LIMIT = quot_t'(32'h8000_0000);
    localparam elem_t POS_SAT   = 32'sh7FFF_FFFF;
    localparam elem_t NEG_SAT   = 32'sh8000_0000;

    typedef struct packed {
        logic dneg;
        logic zero;
    } det_info_t;

    typedef struct packed {
        logic [N_ELEM-1:0][DATA_W-1:0] r;
        logic                          singular;
        logic                          saturated;
    } res_t;

    // cofactor i = m[CA]*m[CB] - m[CC]*m[CD]
    localparam idx_t CA [N_ELEM] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam idx_t CB [N_ELEM] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam idx_t CC [N_ELEM] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam idx_t CD [N_ELEM] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};
    // result element (i,j) takes cofactor (j,i)
    localparam idx_t TR [N_ELEM] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

endpackage

>>> hdl/matrix_inverse_3x3.sv
// Top level: 3x3 Q16.16 matrix inverse by adjugate over determinant.
// Takes one matrix per cycle while s_ready is high, returns one inverse per matrix, in order.
// Between input accept and output valid lie the cofactor products, the
// determinant, the nine divider lanes (one quotient bit per stage, 34
// stages) and the output register. A skid register behind the output
// catches one result under backpressure; while it is full, s_ready is low.
// A zero determinant gives all-zero elements with singular set.
module matrix_inverse_3x3 import mi3_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  elem_t s_a00,
    input  elem_t s_a01,
    input  elem_t s_a02,
    input  elem_t s_a10,
    input  elem_t s_a11,
    input  elem_t s_a12,
    input  elem_t s_a20,
    input  elem_t s_a21,
    input  elem_t s_a22,
    output logic  m_valid,
    input  logic  m_ready,
    output elem_t m_r00,
    output elem_t m_r01,
    output elem_t m_r02,
    output elem_t m_r10,
    output elem_t m_r11,
    output elem_t m_r12,
    output elem_t m_r20,
    output elem_t m_r21,
    output elem_t m_r22,
    output logic  m_singular,
    output logic  m_saturated
);

    logic      en;
    elem_t     a_in    [N_ELEM];
    elem_t     row     [N_ROW];
    cof_t      cof_a   [N_ELEM];
    cof_t      cof_b   [N_ELEM];
    dmag_t     dmag;
    det_info_t info;
    elem_t     lane_r  [N_ELEM];
    logic      lane_sat[N_ELEM];

    logic [PIPE_LAT-1:0] vld_reg;
    logic [LANE_LAT-1:0] zdel_reg;
    logic                pipe_valid;
    res_t                res;
    res_t                out_reg, out_next;
    res_t                skid_reg, skid_next;
    logic                m_valid_reg, m_valid_next;
    logic                skid_valid_reg, skid_valid_next;

    assign a_in = '{s_a00, s_a01, s_a02, s_a10, s_a11, s_a12, s_a20, s_a21, s_a22};
    assign en      = !skid_valid_reg;
    assign s_ready = en && aresetn;

    mi3_cofactor u_cof (
        .aclk    (aclk),
        .en      (en),
        .a_in    (a_in),
        .row_out (row),
        .cof_out (cof_a)
    );

    mi3_det u_det (
        .aclk     (aclk),
        .en       (en),
        .row_in   (row),
        .cof_in   (cof_a),
        .dmag_out (dmag),
        .info_out (info),
        .cof_out  (cof_b)
    );

    for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
        mi3_div_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .c_in    (cof_b[TR[i]]),
            .info_in (info),
            .dmag_in (dmag),
            .r_out   (lane_r[i]),
            .sat_out (lane_sat[i])
        );
    end

    assign pipe_valid = vld_reg[PIPE_LAT-1];

    always_comb begin
        res.singular  = zdel_reg[LANE_LAT-1];
        res.saturated = 1'b0;
        for (int i = 0; i < N_ELEM; i++) begin
            res.r[i]      = res.singular ? '0 : lane_r[i];
            res.saturated = res.saturated | (lane_sat[i] & !res.singular);
        end
    end

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next     = res;
                m_valid_next = pipe_valid;
            end
        end else if (pipe_valid && !skid_valid_reg) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
            end
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zdel_reg <= {zdel_reg[LANE_LAT-2:0], info.zero};
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_r00       = out_reg.r[0];
    assign m_r01       = out_reg.r[1];
    assign m_r02       = out_reg.r[2];
    assign m_r10       = out_reg.r[3];
    assign m_r11       = out_reg.r[4];
    assign m_r12       = out_reg.r[5];
    assign m_r20       = out_reg.r[6];
    assign m_r21       = out_reg.r[7];
    assign m_r22       = out_reg.r[8];
    assign m_singular  = out_reg.singular;
    assign m_saturated = out_reg.saturated;

endmodule

>>> hdl/mi3_cofactor.sv
// Cofactor stage: eighteen products and nine exact cofactors.
module mi3_cofactor import mi3_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  elem_t a_in    [N_ELEM],
    output elem_t row_out [N_ROW],
    output cof_t  cof_out [N_ELEM]
);

    elem_t a_reg    [N_ELEM];
    elem_t row2_reg [N_ROW];
    elem_t row3_reg [N_ROW];
    cof_t  pa_reg   [N_ELEM];
    cof_t  pb_reg   [N_ELEM];
    cof_t  cof_reg  [N_ELEM];
    cof_t  pa_next  [N_ELEM];
    cof_t  pb_next  [N_ELEM];
    cof_t  cof_next [N_ELEM];

    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            pa_next[i]  = a_reg[CA[i]] * a_reg[CB[i]];
            pb_next[i]  = a_reg[CC[i]] * a_reg[CD[i]];
            cof_next[i] = pa_reg[i] - pb_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N_ELEM; i++) begin
                a_reg[i]   <= a_in[i];
                pa_reg[i]  <= pa_next[i];
                pb_reg[i]  <= pb_next[i];
                cof_reg[i] <= cof_next[i];
            end
            for (int j = 0; j < N_ROW; j++) begin
                row2_reg[j] <= a_reg[j];
                row3_reg[j] <= row2_reg[j];
            end
        end
    end

    assign row_out = row3_reg;
    assign cof_out = cof_reg;

endmodule

>>> hdl/mi3_det.sv
// Determinant stage: split products, term sums, magnitude, sign and zero flag.
module mi3_det import mi3_pkg::*; (
    input  logic      aclk,
    input  logic      en,
    input  elem_t     row_in   [N_ROW],
    input  cof_t      cof_in   [N_ELEM],
    output dmag_t     dmag_out,
    output det_info_t info_out,
    output cof_t      cof_out  [N_ELEM]
);

    logic signed [2*DATA_W:0] plo_reg  [N_ROW];
    cof_t                     phi_reg  [N_ROW];
    det_t                     term_reg [N_ROW];
    det_t                     det_reg;
    dmag_t                    dmag_reg;
    det_info_t                info_reg;
    cof_t                     cdel_reg [DET_LAT][N_ELEM];

    logic signed [2*DATA_W:0] plo_next  [N_ROW];
    cof_t                     phi_next  [N_ROW];
    det_t                     term_next [N_ROW];
    det_t                     det_next;
    det_t                     dabs;

    always_comb begin
        for (int j = 0; j < N_ROW; j++) begin
            plo_next[j]  = $signed({1'b0, cof_in[j][DATA_W-1:0]}) * row_in[j];
            phi_next[j]  = $signed(cof_in[j][COF_W-1:DATA_W]) * row_in[j];
            term_next[j] = (DET_W'(phi_reg[j]) <<< DATA_W) + DET_W'(plo_reg[j]);
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
        dabs     = det_reg[DET_W-1] ? -det_reg : det_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < N_ROW; j++) begin
                plo_reg[j]  <= plo_next[j];
                phi_reg[j]  <= phi_next[j];
                term_reg[j] <= term_next[j];
            end
            det_reg       <= det_next;
            dmag_reg      <= dabs[DM_W-1:0];
            info_reg.dneg <= det_reg[DET_W-1];
            info_reg.zero <= (det_reg == '0);
            cdel_reg[0]   <= cof_in;
            for (int s = 1; s < DET_LAT; s++) begin
                cdel_reg[s] <= cdel_reg[s-1];
            end
        end
    end

    assign dmag_out = dmag_reg;
    assign info_out = info_reg;
    assign cof_out  = cdel_reg[DET_LAT-1];

endmodule

>>> hdl/mi3_div_lane.sv
// Divider lane: pipelined restoring division of one cofactor, with saturation.
module mi3_div_lane import mi3_pkg::*; (
    input  logic      aclk,
    input  logic      en,
    input  cof_t      c_in,
    input  det_info_t info_in,
    input  dmag_t     dmag_in,
    output elem_t     r_out,
    output logic      sat_out
);

    logic [NUM_W-1:0] rem_reg  [Q_W+1];
    quot_t            q_reg    [Q_W+1];
    dmag_t            dm_reg   [Q_W+1];
    logic             neg_reg  [Q_W+1];
    logic [NUM_W-1:0] rem_next [Q_W+1];
    quot_t            q_next   [Q_W+1];
    logic [COF_W-1:0] cmag;
    quot_t            qf;

    always_comb begin
        cmag        = c_in[COF_W-1] ? COF_W'(-c_in) : COF_W'(c_in);
        rem_next[0] = NUM_W'(cmag) << (2 * FRAC_BITS);
        q_next[0]   = '0;
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_step
        localparam int K = Q_W - 1 - s;
        logic [CMP_W-1:0] rem_x;
        logic [CMP_W-1:0] den_x;
        logic             ge;
        always_comb begin
            rem_x = CMP_W'(rem_reg[s]);
            den_x = CMP_W'(dm_reg[s]) << K;
            ge    = (rem_x >= den_x);
            rem_next[s+1]    = ge ? rem_reg[s] - den_x[NUM_W-1:0] : rem_reg[s];
            q_next[s+1]      = q_reg[s];
            q_next[s+1][K]   = ge;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= Q_W; s++) begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
            end
            dm_reg[0]  <= dmag_in;
            neg_reg[0] <= c_in[COF_W-1] ^ info_in.dneg;
            for (int s = 1; s <= Q_W; s++) begin
                dm_reg[s]  <= dm_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    always_comb begin
        qf = q_reg[Q_W];
        if (!neg_reg[Q_W]) begin
            sat_out = (qf > POS_LIMIT);
            r_out   = sat_out ? POS_SAT : elem_t'(qf[DATA_W-1:0]);
        end else begin
            sat_out = (qf > NEG_LIMIT);
            r_out   = sat_out ? NEG_SAT : elem_t'(-qf[DATA_W-1:0]);
        end
    end

endmodule
